// ===== hw/rtl/ctsp_pkg.sv =====
// shared types, constants and the known code table of the tuple stream parser
// no dependencies
`default_nettype none

package ctsp_pkg;

	localparam int MAX_LIST_BYTES = 1024;
	localparam int CNT_W = $clog2(MAX_LIST_BYTES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LIST_BYTES);

	localparam logic [7:0] CODE_NULL = 8'h00;
	localparam logic [7:0] CODE_END  = 8'hFF;
	localparam logic [7:0] LEN_END   = 8'hFF;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	typedef enum logic [1:0] {
		PH_CODE = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef struct packed {
		logic       known;
		logic       any_len;
		logic [7:0] len;
	} len_rule_t;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] tuple_code;
		logic [7:0] tuple_length;
		logic       rejected;
		logic [7:0] data_value;
		logic [7:0] data_index;
		logic       tuple_last;
		logic       list_done;
	} result_t;

	// required length per code, or free length, or unknown
	function automatic len_rule_t known_length(input logic [7:0] c);
		len_rule_t r;
		r = '{known: 1'b1, any_len: 1'b0, len: 8'd0};
		case (c) inside
			8'h00, 8'h14:                     r.len = 8'd0;
			8'h10:                            r.len = 8'd5;
			8'h11, 8'h12, 8'h20, 8'h42,
			8'h44, 8'h45:                     r.len = 8'd4;
			8'h13:                            r.len = 8'd3;
			8'h23, 8'h43:                     r.len = 8'd2;
			8'h01, [8'h15:8'h1F], 8'h21, 8'h22,
			8'h40, 8'h41, 8'h46, 8'hFF:       r.any_len = 1'b1;
			default:                          r.known = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cis_tuple_stream_parser_unit.sv =====
// top level of the card information structure tuple stream parser
// depends on ctsp_pkg, ctsp_parse_core and ctsp_out_reg
`default_nettype none

// Splits a card information structure, one byte per request, into tuples:
// a header result at each length byte (validated code, length, reject flag)
// and one data result per data byte. Null codes give no result; a length of
// 0xFF makes a terminator of length zero; the list ends after a terminator,
// or once a tuple completes or a null code arrives with MAX_LIST_BYTES or
// more bytes taken, and then bytes are dropped until one arrives with
// start_list set. The block takes one byte per clock cycle while the result
// register can load, and stalls while it holds a result not yet taken. Each
// byte passes one input register, then the table check and counter update
// feeding the result register. Code, null and after-end bytes give no result.

module cis_tuple_stream_parser_unit
	import ctsp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       start_list,
	input  wire logic [7:0] cis_byte,

	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            item_kind,
	output logic [7:0]      tuple_code,
	output logic [7:0]      tuple_length,
	output logic            rejected,
	output logic [7:0]      data_value,
	output logic [7:0]      data_index,
	output logic            tuple_last,
	output logic            list_done
);

	// input stage
	logic       valid_s1;
	logic       start_s1;
	logic [7:0] byte_s1;

	logic       has_result;
	result_t    result;
	logic       can_load;
	logic       advance;
	result_t    out_data;

	// the held byte moves on when it has no result or the result register frees up
	assign advance  = valid_s1 && (!has_result || can_load);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			start_s1 <= start_list;
			byte_s1  <= cis_byte;
		end
	end

	// parser state and per-byte decode, updated only when the byte moves on
	ctsp_parse_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.start_list (start_s1),
		.cis_byte   (byte_s1),
		.has_result (has_result),
		.result     (result)
	);

	// result register, loads only bytes that produce a result
	ctsp_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (advance && has_result),
		.load_data  (result),
		.can_load   (can_load),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	assign item_kind    = out_data.item_kind;
	assign tuple_code   = out_data.tuple_code;
	assign tuple_length = out_data.tuple_length;
	assign rejected     = out_data.rejected;
	assign data_value   = out_data.data_value;
	assign data_index   = out_data.data_index;
	assign tuple_last   = out_data.tuple_last;
	assign list_done    = out_data.list_done;

endmodule

`default_nettype wire

// ===== hw/rtl/ctsp_parse_core.sv =====
// tuple parser state and per-byte result logic
// depends on ctsp_pkg
`default_nettype none

module ctsp_parse_core
	import ctsp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic       start_list,
	input  wire logic [7:0] cis_byte,
	output logic            has_result,
	output result_t         result
);

	phase_t           phase_q, ph_e, ph_d;
	logic [7:0]       held_q, held_e, held_d;
	logic [7:0]       left_q, left_e, left_d;
	logic [7:0]       pos_q, pos_e, pos_d;
	logic [CNT_W-1:0] cnt_q, cnt_e, cnt_inc;
	logic             term_q, term_e, term_d;

	logic             limit;
	logic [7:0]       code_l, len_l, left_dec;
	len_rule_t        rule;
	logic             bad, term_l;

	// start byte resets the state seen by this byte
	always_comb begin
		ph_e   = start_list ? PH_CODE : phase_q;
		held_e = start_list ? 8'd0 : held_q;
		left_e = start_list ? 8'd0 : left_q;
		pos_e  = start_list ? 8'd0 : pos_q;
		cnt_e  = start_list ? '0 : cnt_q;
		term_e = start_list ? 1'b0 : term_q;
	end

	always_comb begin
		cnt_inc  = (cnt_e < MAX_CNT) ? cnt_e + CNT_W'(1) : cnt_e;
		limit    = (cnt_inc >= MAX_CNT);
		code_l   = (cis_byte == LEN_END) ? CODE_END : held_e;
		len_l    = (cis_byte == LEN_END) ? 8'd0 : cis_byte;
		rule     = known_length(code_l);
		bad      = !rule.known || (!rule.any_len && (rule.len != len_l));
		term_l   = (code_l == CODE_END);
		left_dec = (left_e != 8'd0) ? left_e - 8'd1 : left_e;
	end

	// next state
	always_comb begin
		ph_d   = ph_e;
		held_d = held_e;
		left_d = left_e;
		pos_d  = pos_e;
		term_d = term_e;
		case (ph_e)
			PH_CODE: begin
				if (cis_byte == CODE_NULL) begin
					if (limit) ph_d = PH_DONE;
				end else begin
					held_d = cis_byte;
					ph_d   = PH_LEN;
				end
			end
			PH_LEN: begin
				term_d = term_l;
				held_d = bad ? 8'd0 : code_l;
				if (len_l == 8'd0) begin
					ph_d = (term_l || limit) ? PH_DONE : PH_CODE;
				end else begin
					left_d = len_l;
					pos_d  = 8'd0;
					ph_d   = PH_DATA;
				end
			end
			PH_DATA: begin
				left_d = left_dec;
				pos_d  = pos_e + 8'd1;
				if (left_dec == 8'd0) ph_d = (term_e || limit) ? PH_DONE : PH_CODE;
			end
			default: ;
		endcase
	end

	// result
	always_comb begin
		has_result = 1'b0;
		result     = '0;
		case (ph_e)
			PH_LEN: begin
				has_result          = 1'b1;
				result.item_kind    = KIND_HEADER;
				result.tuple_code   = bad ? 8'd0 : code_l;
				result.tuple_length = len_l;
				result.rejected     = bad;
				result.tuple_last   = (len_l == 8'd0);
				result.list_done    = (len_l == 8'd0) && (term_l || limit);
			end
			PH_DATA: begin
				has_result          = 1'b1;
				result.item_kind    = KIND_DATA;
				result.tuple_code   = held_e;
				result.tuple_length = pos_e + left_e;
				result.rejected     = (held_e == 8'd0);
				result.data_value   = cis_byte;
				result.data_index   = pos_e;
				result.tuple_last   = (left_dec == 8'd0);
				result.list_done    = (left_dec == 8'd0) && (term_e || limit);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CODE;
			held_q  <= 8'd0;
			left_q  <= 8'd0;
			pos_q   <= 8'd0;
			cnt_q   <= '0;
			term_q  <= 1'b0;
		end else if (step) begin
			phase_q <= ph_d;
			held_q  <= held_d;
			left_q  <= left_d;
			pos_q   <= pos_d;
			cnt_q   <= (ph_e == PH_DONE) ? cnt_e : cnt_inc;
			term_q  <= term_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ctsp_out_reg.sv =====
// result register between parser logic and the output channel
// depends on ctsp_pkg
`default_nettype none

module ctsp_out_reg
	import ctsp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load_valid,
	input  wire result_t load_data,
	output logic         can_load,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	logic    valid_q;
	result_t data_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load_valid) data_q <= load_data;
	end

endmodule

`default_nettype wire

// ===== tb/tb_cis_tuple_stream_parser_unit.sv =====
`timescale 1ns / 100ps
// self-checking testbench for cis_tuple_stream_parser_unit: directed, random and byte limit lists
// depends on ctsp_pkg and the rtl of cis_tuple_stream_parser_unit

module tb_cis_tuple_stream_parser_unit;
	import ctsp_pkg::*;

	// tuple codes of the card information structure
	localparam logic [7:0] TPL_DEVICE        = 8'h01;
	localparam logic [7:0] TPL_CHECKSUM      = 8'h10;
	localparam logic [7:0] TPL_LONGLINK_A    = 8'h11;
	localparam logic [7:0] TPL_LONGLINK_C    = 8'h12;
	localparam logic [7:0] TPL_LINKTARGET    = 8'h13;
	localparam logic [7:0] TPL_NO_LINK       = 8'h14;
	localparam logic [7:0] TPL_VERS_1        = 8'h15;
	localparam logic [7:0] TPL_ALTSTR        = 8'h16;
	localparam logic [7:0] TPL_DEVICE_A      = 8'h17;
	localparam logic [7:0] TPL_JEDEC_C       = 8'h18;
	localparam logic [7:0] TPL_JEDEC_A       = 8'h19;
	localparam logic [7:0] TPL_CONFIG        = 8'h1A;
	localparam logic [7:0] TPL_CFTABLE_ENTRY = 8'h1B;
	localparam logic [7:0] TPL_DEVICE_OC     = 8'h1C;
	localparam logic [7:0] TPL_DEVICE_OA     = 8'h1D;
	localparam logic [7:0] TPL_DEVICE_GEO    = 8'h1E;
	localparam logic [7:0] TPL_DEVICE_GEO_A  = 8'h1F;
	localparam logic [7:0] TPL_MANFID        = 8'h20;
	localparam logic [7:0] TPL_FUNCID        = 8'h21;
	localparam logic [7:0] TPL_FUNCE         = 8'h22;
	localparam logic [7:0] TPL_SWIL          = 8'h23;
	localparam logic [7:0] TPL_VERS_2        = 8'h40;
	localparam logic [7:0] TPL_FORMAT        = 8'h41;
	localparam logic [7:0] TPL_GEOMETRY      = 8'h42;
	localparam logic [7:0] TPL_BYTEORDER     = 8'h43;
	localparam logic [7:0] TPL_DATE          = 8'h44;
	localparam logic [7:0] TPL_BATTERY       = 8'h45;
	localparam logic [7:0] TPL_ORG           = 8'h46;
	localparam logic [7:0] TPL_UNASSIGNED    = 8'h80;

	localparam logic [7:0] KNOWN_CODES [27] = '{
		TPL_DEVICE, TPL_CHECKSUM, TPL_LONGLINK_A, TPL_LONGLINK_C, TPL_LINKTARGET,
		TPL_NO_LINK, TPL_VERS_1, TPL_ALTSTR, TPL_DEVICE_A, TPL_JEDEC_C, TPL_JEDEC_A,
		TPL_CONFIG, TPL_CFTABLE_ENTRY, TPL_DEVICE_OC, TPL_DEVICE_OA, TPL_DEVICE_GEO,
		TPL_DEVICE_GEO_A, TPL_MANFID, TPL_FUNCID, TPL_FUNCE, TPL_SWIL, TPL_VERS_2,
		TPL_FORMAT, TPL_GEOMETRY, TPL_BYTEORDER, TPL_DATE, TPL_BATTERY
	};

	// length rule outcomes besides a fixed count
	localparam int NOT_KNOWN = -1;
	localparam int FREE_LEN  = -2;

	localparam int MAX_PRINTED = 200;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       start_list = 1'b0;
	logic [7:0] cis_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       item_kind;
	logic [7:0] tuple_code;
	logic [7:0] tuple_length;
	logic       rejected;
	logic [7:0] data_value;
	logic [7:0] data_index;
	logic       tuple_last;
	logic       list_done;

	// parser state as the scoreboard sees it
	phase_t     ps_phase;
	logic [7:0] ps_code;
	int         ps_left;
	logic [7:0] ps_pos;
	int         ps_consumed;
	bit         ps_terminating;

	result_t    expected_q [$];
	int         mismatch_count;
	int         results_seen;
	int         live_bytes;

	// idling knobs and the long receiver hold-off request
	int         send_idle_pct;
	int         recv_stall_pct;
	int         hold_len;
	int         hold_seq;
	int         hold_seen;
	int         hold_left;

	cis_tuple_stream_parser_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_list   (start_list),
		.cis_byte     (cis_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.item_kind    (item_kind),
		.tuple_code   (tuple_code),
		.tuple_length (tuple_length),
		.rejected     (rejected),
		.data_value   (data_value),
		.data_index   (data_index),
		.tuple_last   (tuple_last),
		.list_done    (list_done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// required data length of a tuple code
	function automatic int required_len(input logic [7:0] code);
		case (code)
			CODE_NULL, TPL_NO_LINK:                        return 0;
			TPL_CHECKSUM:                                  return 5;
			TPL_LONGLINK_A, TPL_LONGLINK_C, TPL_MANFID,
			TPL_GEOMETRY, TPL_DATE, TPL_BATTERY:           return 4;
			TPL_LINKTARGET:                                return 3;
			TPL_SWIL, TPL_BYTEORDER:                       return 2;
			TPL_DEVICE, TPL_VERS_1, TPL_ALTSTR, TPL_DEVICE_A, TPL_JEDEC_C,
			TPL_JEDEC_A, TPL_CONFIG, TPL_CFTABLE_ENTRY, TPL_DEVICE_OC,
			TPL_DEVICE_OA, TPL_DEVICE_GEO, TPL_DEVICE_GEO_A, TPL_FUNCID,
			TPL_FUNCE, TPL_VERS_2, TPL_FORMAT, TPL_ORG, CODE_END:
				return FREE_LEN;
			default:                                       return NOT_KNOWN;
		endcase
	endfunction

	task automatic clear_parser();
		ps_phase = PH_CODE;
		ps_code = 8'h00;
		ps_left = 0;
		ps_pos = 8'h00;
		ps_consumed = 0;
		ps_terminating = 1'b0;
	endtask

	// advance the parser by one accepted byte and queue the result it gives
	task automatic parse_byte(input logic start, input logic [7:0] b);
		result_t    r;
		logic [7:0] code;
		logic [7:0] len;
		int         need;
		bit         bad;
		bit         done;
		if (start)
			clear_parser();
		if (ps_phase != PH_DONE)
			live_bytes++;
		r = '0;
		case (ps_phase)
			PH_CODE: begin
				if (ps_consumed < MAX_LIST_BYTES)
					ps_consumed++;
				if (b == CODE_NULL) begin
					// null byte can still close the list at the limit
					if (ps_consumed >= MAX_LIST_BYTES)
						ps_phase = PH_DONE;
				end else begin
					ps_code = b;
					ps_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				code = ps_code;
				len = b;
				if (ps_consumed < MAX_LIST_BYTES)
					ps_consumed++;
				if (len == LEN_END) begin
					len = 8'h00;
					code = CODE_END;
				end
				need = required_len(code);
				bad = (need == NOT_KNOWN) || (need != FREE_LEN && need != int'(len));
				ps_terminating = (code == CODE_END);
				ps_code = bad ? CODE_NULL : code;
				r.item_kind = KIND_HEADER;
				r.tuple_code = ps_code;
				r.tuple_length = len;
				r.rejected = bad;
				if (len == 8'h00) begin
					done = ps_terminating || ps_consumed >= MAX_LIST_BYTES;
					r.tuple_last = 1'b1;
					r.list_done = done;
					ps_phase = done ? PH_DONE : PH_CODE;
				end else begin
					ps_left = len;
					ps_pos = 8'h00;
					ps_phase = PH_DATA;
				end
				expected_q.push_back(r);
			end
			PH_DATA: begin
				if (ps_consumed < MAX_LIST_BYTES)
					ps_consumed++;
				r.item_kind = KIND_DATA;
				r.tuple_code = ps_code;
				r.tuple_length = ps_pos + 8'(ps_left);
				r.rejected = (ps_code == CODE_NULL);
				r.data_value = b;
				r.data_index = ps_pos;
				if (ps_left > 0)
					ps_left--;
				ps_pos = ps_pos + 8'd1;
				if (ps_left == 0) begin
					done = ps_terminating || ps_consumed >= MAX_LIST_BYTES;
					r.tuple_last = 1'b1;
					r.list_done = done;
					ps_phase = done ? PH_DONE : PH_CODE;
				end
				expected_q.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
				results_seen, name, got, want));
	endtask

	// one request: optional idle gap, then hold valid until accepted
	// entered and left at a falling edge
	task automatic send_byte(input logic start, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		start_list <= start;
		cis_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		parse_byte(start, b);
		@(negedge clk);
	endtask

	// code, length and random data bytes of one tuple
	task automatic send_tuple(input logic first, input logic [7:0] code,
			input logic [7:0] len);
		send_byte(first, code);
		send_byte(1'b0, len);
		if (len != LEN_END)
			repeat (len) send_byte(1'b0, 8'($urandom));
	endtask

	task automatic set_idling(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	// mostly well formed list with random tuples, sometimes noise or cut short
	task automatic send_random_list(input int max_tuples);
		int         n_tuples;
		int         t;
		int         pick;
		int         need;
		logic [7:0] code;
		logic [7:0] len;
		logic       first;
		first = 1'b1;
		if ($urandom_range(99) < 5) begin
			repeat ($urandom_range(12, 1))
				send_byte($urandom_range(9) == 0, 8'($urandom));
			return;
		end
		n_tuples = $urandom_range(max_tuples, 1);
		for (t = 0; t < n_tuples; t++) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_byte(first, CODE_NULL);
				first = 1'b0;
				continue;
			end
			if (pick < 16) begin
				do
					code = 8'($urandom_range(254, 1));
				while (required_len(code) != NOT_KNOWN);
				len = 8'($urandom_range(6));
			end else begin
				code = KNOWN_CODES[$urandom_range(26)];
				need = required_len(code);
				if (need == FREE_LEN)
					len = ($urandom_range(29) == 0) ? 8'($urandom_range(254))
						: 8'($urandom_range(10));
				else if (pick < 26)
					len = 8'(need) ^ 8'($urandom_range(3, 1));
				else
					len = 8'(need);
			end
			send_tuple(first, code, len);
			first = 1'b0;
		end
		pick = $urandom_range(99);
		if (pick < 10) begin
			// left in mid tuple, the next list start drops it
			send_byte(first, TPL_CONFIG);
			send_byte(1'b0, 8'($urandom_range(8, 2)));
			send_byte(1'b0, 8'($urandom));
		end else if (pick < 45) begin
			send_tuple(first, KNOWN_CODES[$urandom_range(26)], LEN_END);
		end else if (pick < 60) begin
			send_tuple(first, CODE_END, 8'($urandom_range(4, 1)));
		end else begin
			send_tuple(first, CODE_END, LEN_END);
		end
		if ($urandom_range(99) < 30)
			repeat ($urandom_range(3, 1)) send_byte(1'b0, 8'($urandom));
	endtask

	// 1020 bytes of list: three full size tuples and one of 250 data bytes
	task automatic send_long_prefix();
		send_tuple(1'b1, TPL_CONFIG, 8'd254);
		send_tuple(1'b0, TPL_CFTABLE_ENTRY, 8'd254);
		send_tuple(1'b0, TPL_ORG, 8'd254);
		send_tuple(1'b0, TPL_VERS_1, 8'd250);
	endtask

	// field extremes, every tuple outcome and the named corner cases
	task automatic test_directed();
		send_byte(1'b1, TPL_LINKTARGET);
		send_byte(1'b0, 8'd3);
		send_byte(1'b0, 8'h00);
		send_byte(1'b0, 8'hFF);
		send_byte(1'b0, 8'h5A);
		send_byte(1'b0, CODE_NULL);
		// zero length tuple is a lone header
		send_byte(1'b0, TPL_NO_LINK);
		send_byte(1'b0, 8'd0);
		// fixed length code with the wrong length
		send_byte(1'b0, TPL_MANFID);
		send_byte(1'b0, 8'd1);
		send_byte(1'b0, 8'hA5);
		// code missing from the table
		send_byte(1'b0, TPL_UNASSIGNED);
		send_byte(1'b0, 8'd0);
		// length 0xff turns any code into the terminator
		send_byte(1'b0, TPL_CHECKSUM);
		send_byte(1'b0, LEN_END);
		// bytes after the end are dropped
		send_byte(1'b0, 8'hFF);
		send_byte(1'b0, 8'h00);
		// terminator code with a real length passes its data on
		send_byte(1'b1, CODE_END);
		send_byte(1'b0, 8'd2);
		send_byte(1'b0, 8'h11);
		send_byte(1'b0, 8'hEE);
		// restart in mid tuple
		send_byte(1'b1, TPL_CONFIG);
		send_byte(1'b0, 8'd4);
		send_byte(1'b0, 8'h01);
		send_byte(1'b1, TPL_VERS_1);
		send_byte(1'b0, LEN_END);
	endtask

	task automatic test_random_traffic(input int n_bytes);
		int first_count;
		first_count = live_bytes;
		while (live_bytes - first_count < n_bytes)
			send_random_list(6);
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		hold_len = 300;
		hold_seq++;
		send_tuple(1'b1, TPL_VERS_1, 8'd60);
		send_tuple(1'b0, CODE_END, LEN_END);
	endtask

	// sender waits in mid tuple until every result is out
	task automatic test_drain_pause();
		send_byte(1'b1, TPL_DATE);
		send_byte(1'b0, 8'd4);
		send_byte(1'b0, 8'($urandom));
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		@(negedge clk);
		repeat (3) send_byte(1'b0, 8'($urandom));
		send_tuple(1'b0, TPL_FUNCID, LEN_END);
	endtask

	// list ends on a data tuple finishing after the byte count saturated
	task automatic test_byte_limit();
		send_long_prefix();
		send_tuple(1'b0, TPL_NO_LINK, 8'd0);
		send_tuple(1'b0, TPL_FUNCID, 8'd2);
		// dropped, the list is over
		send_byte(1'b0, TPL_MANFID);
		send_byte(1'b0, 8'd4);
	endtask

	// receiver: random stalls, or a long hold-off counted here
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare every accepted result with the oldest expected one
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					results_seen));
			end else begin
				want = expected_q.pop_front();
				check_field("item_kind", item_kind, want.item_kind);
				check_field("tuple_code", tuple_code, want.tuple_code);
				check_field("tuple_length", tuple_length, want.tuple_length);
				check_field("rejected", rejected, want.rejected);
				check_field("data_value", data_value, want.data_value);
				check_field("data_index", data_index, want.data_index);
				check_field("tuple_last", tuple_last, want.tuple_last);
				check_field("list_done", list_done, want.list_done);
			end
			results_seen++;
		end
	end

	initial begin
		int drain_cycles;
		mismatch_count = 0;
		results_seen = 0;
		live_bytes = 0;
		hold_len = 0;
		hold_seq = 0;
		hold_seen = 0;
		hold_left = 0;
		set_idling(0, 0);
		clear_parser();

		// reset held low at the start, released at a falling edge
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		test_directed();

		// random lists under each idling mix
		test_random_traffic(40);
		set_idling(70, 0);
		test_random_traffic(40);
		set_idling(0, 70);
		test_random_traffic(40);
		set_idling(26, 26);
		test_random_traffic(40);

		set_idling(0, 0);
		test_backpressure();
		set_idling(26, 26);
		test_drain_pause();
		test_byte_limit();
		test_random_traffic(20);

		// stop requesting and let the results drain
		in_valid <= 1'b0;
		set_idling(0, 0);
		drain_cycles = 0;
		while (expected_q.size() != 0 && drain_cycles < 20000) begin
			@(negedge clk);
			drain_cycles++;
		end
		repeat (16) @(negedge clk);
		if (expected_q.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_q.size()));

		if (mismatch_count == 0)
			$display("** cis_tuple_stream_parser_unit: PASSED **");
		else
			$display("** cis_tuple_stream_parser_unit: FAILED **");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#3000000;
		$display("** cis_tuple_stream_parser_unit: FAILED **");
		$finish;
	end

endmodule
